// ----- design/pida_pkg.sv -----
// ----------------------------------------------------------------------------
// pida_pkg
// shared types, register indexes and helpers for the deadband pi controller
// ----------------------------------------------------------------------------
package pida_pkg;

  localparam logic [23:0] MS_PER_MINUTE = 24'd60000;
  localparam logic [6:0]  MUL_STEPS     = 7'd24;
  localparam logic [6:0]  DIV_STEPS     = 7'd64;

  localparam logic [23:0] GAIN_RESET  = 24'd256;
  localparam logic [23:0] ITIME_RESET = 24'd256;
  localparam logic [23:0] OMAX_RESET  = 24'h7FFFFF;

  typedef enum logic [2:0] {
    REG_GAIN  = 3'd0,
    REG_ITIME = 3'd1,
    REG_DBAND = 3'd2,
    REG_OMIN  = 3'd3,
    REG_OMAX  = 3'd4
  } reg_idx_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DT,
    ST_DIV_MIN,
    ST_DIV_TI,
    ST_MUL_GAIN,
    ST_CHECK,
    ST_DIV_LIM,
    ST_MUL_BACK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    op_t         op;
    logic [63:0] opa;
    logic [23:0] opb;
  } su_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } su_stat_t;

  function automatic logic [47:0] sat48(input logic signed [63:0] v);
    logic [47:0] r;
    if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
      r = 48'h7FFF_FFFF_FFFF;
    end else if (v < -64'sh0000_8000_0000_0000) begin
      r = 48'h8000_0000_0000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

// ----- design/pi_deadband_antiwindup.sv -----
// sequence: each input beat runs a multiply, two divides and a multiply on the shared
//   unit, then a divide and a multiply more when the integral is back-computed at a limit
// throughput: one item at a time; the next input beat is taken the cycle after the
//   result beat, the pace set by the one shared bit-serial unit (one bit a cycle)
// reset: synchronous active-low rst_n clears the integral, loads register defaults
// ----------------------------------------------------------------------------
// pi_deadband_antiwindup
// pi airflow controller with error dead band and back-calculation anti-windup
// ----------------------------------------------------------------------------
module pi_deadband_antiwindup import pida_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_target_level,
  input  logic [15:0] in_measured_level,
  input  logic [15:0] in_elapsed_ms,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [23:0] out_airflow_rate,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [23:0] gain_r, itime_r, omin_r, omax_r;
  logic [15:0] dband_r;
  reg_idx_t    widx;

  // sequencer and datapath registers
  state_t      state_r, state_nxt;
  logic        issued_r, issued_nxt;
  logic [47:0] integ_r, integ_nxt;   // integral, Q32.16
  logic [47:0] acc_r,   acc_nxt;     // advanced integral
  logic        ebneg_r, ebneg_nxt;
  logic [15:0] ebmag_r, ebmag_nxt;   // banded error magnitude
  logic [15:0] ms_r,    ms_nxt;
  logic [63:0] t1_r,    t1_nxt;      // dividend for the minute scaling
  logic [63:0] s_r,     s_nxt;       // sum term s, or back-computed q
  logic [40:0] m_r,     m_nxt;       // candidate magnitude
  logic [23:0] lim_r,   lim_nxt;
  logic [23:0] res_r,   res_nxt;

  su_cmd_t     cmd;
  su_stat_t    stat;
  logic [87:0] prod;
  logic [63:0] quot;

  // effective gain and integral time, zero reads as one lsb
  logic [23:0] g_eff, t_eff;
  assign g_eff = (gain_r  == 24'd0) ? 24'd1 : gain_r;
  assign t_eff = (itime_r == 24'd0) ? 24'd1 : itime_r;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_RESET;
      itime_r <= ITIME_RESET;
      dband_r <= 16'd0;
      omin_r  <= 24'd0;
      omax_r  <= OMAX_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (widx)
        REG_GAIN:  gain_r  <= pwdata[23:0];
        REG_ITIME: itime_r <= pwdata[23:0];
        REG_DBAND: dband_r <= pwdata[15:0];
        REG_OMIN:  omin_r  <= pwdata[23:0];
        REG_OMAX:  omax_r  <= pwdata[23:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_GAIN:  prdata = {8'd0, gain_r};
      REG_ITIME: prdata = {8'd0, itime_r};
      REG_DBAND: prdata = {16'd0, dband_r};
      REG_OMIN:  prdata = {8'd0, omin_r};
      REG_OMAX:  prdata = {8'd0, omax_r};
      default:   prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- dead band
  logic signed [17:0] err, dbs, ebv;
  always_comb begin
    err = $signed({2'b00, in_target_level}) - $signed({2'b00, in_measured_level});
    dbs = $signed({2'b00, dband_r});
    if (err > dbs)       ebv = err - dbs;
    else if (err < -dbs) ebv = err + dbs;
    else                 ebv = 18'sd0;
  end

  // banded error scaled to Q.16, sign applied
  logic [63:0] eb64;
  assign eb64 = ebneg_r ? (64'd0 - {32'd0, ebmag_r, 16'd0}) : {32'd0, ebmag_r, 16'd0};

  // ---------------------------------------------------------------- serial unit
  pida_serial_unit u_su (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd_i  (cmd),
    .stat_o (stat),
    .prod_o (prod),
    .quot_o (quot)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      issued_r <= 1'b0;
      integ_r  <= 48'd0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
      integ_r  <= integ_nxt;
    end
    acc_r   <= acc_nxt;
    ebneg_r <= ebneg_nxt;
    ebmag_r <= ebmag_nxt;
    ms_r    <= ms_nxt;
    t1_r    <= t1_nxt;
    s_r     <= s_nxt;
    m_r     <= m_nxt;
    lim_r   <= lim_nxt;
    res_r   <= res_nxt;
  end

  // scratch values of the capture steps
  logic [63:0] qs, sum64, amag;
  logic [88:0] rnd;
  logic [41:0] cand, lo42, hi42;
  logic [80:0] rb;
  logic [47:0] mb;

  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    integ_nxt  = integ_r;
    acc_nxt    = acc_r;
    ebneg_nxt  = ebneg_r;
    ebmag_nxt  = ebmag_r;
    ms_nxt     = ms_r;
    t1_nxt     = t1_r;
    s_nxt      = s_r;
    m_nxt      = m_r;
    lim_nxt    = lim_r;
    res_nxt    = res_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.start  = 1'b0;
    cmd.op     = OP_MUL;
    cmd.opa    = 64'd0;
    cmd.opb    = 24'd0;
    qs    = 64'd0;
    sum64 = 64'd0;
    amag  = abs64({{16{acc_r[47]}}, acc_r});
    rnd   = 89'd0;
    rb    = 81'd0;
    mb    = 48'd0;
    // candidate has the opposite sign of s
    cand  = s_r[63] ? {1'b0, m_r} : (42'd0 - {1'b0, m_r});
    lo42  = {{18{omin_r[23]}}, omin_r};
    hi42  = {{18{omax_r[23]}}, omax_r};

    if (state_r != ST_IDLE && state_r != ST_OUT && state_r != ST_CHECK && !issued_r) begin
      cmd.start  = 1'b1;
      issued_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ebneg_nxt = ebv[17];
          ebmag_nxt = ebv[17] ? 16'(-ebv) : ebv[15:0];
          ms_nxt    = in_elapsed_ms;
          state_nxt = ST_MUL_DT;
        end
      end
      // |eb| * elapsed_ms
      ST_MUL_DT: begin
        cmd.op  = OP_MUL;
        cmd.opa = {48'd0, ebmag_r};
        cmd.opb = {8'd0, ms_r};
        if (stat.done) begin
          t1_nxt     = {16'd0, prod[31:0], 16'd0} + {40'd0, MS_PER_MINUTE >> 1};
          issued_nxt = 1'b0;
          state_nxt  = ST_DIV_MIN;
        end
      end
      // scale to minutes, advance the integral
      ST_DIV_MIN: begin
        cmd.op  = OP_DIV;
        cmd.opa = t1_r;
        cmd.opb = MS_PER_MINUTE;
        if (stat.done) begin
          qs         = ebneg_r ? (64'd0 - quot) : quot;
          sum64      = {{16{integ_r[47]}}, integ_r} + qs;
          acc_nxt    = sat48(sum64);
          issued_nxt = 1'b0;
          state_nxt  = ST_DIV_TI;
        end
      end
      // integral over integral time
      ST_DIV_TI: begin
        cmd.op  = OP_DIV;
        cmd.opa = {amag[55:0], 8'd0} + {41'd0, t_eff[23:1]};
        cmd.opb = t_eff;
        if (stat.done) begin
          qs         = acc_r[47] ? (64'd0 - quot) : quot;
          s_nxt      = eb64 + qs;
          issued_nxt = 1'b0;
          state_nxt  = ST_MUL_GAIN;
        end
      end
      // gain times s, rounded and capped
      ST_MUL_GAIN: begin
        cmd.op  = OP_MUL;
        cmd.opa = abs64(s_r);
        cmd.opb = g_eff;
        if (stat.done) begin
          rnd        = {1'b0, prod} + 89'h80_0000;
          m_nxt      = (rnd[88:24] > 65'h100_0000_0000) ? 41'h100_0000_0000 : rnd[64:24];
          issued_nxt = 1'b0;
          state_nxt  = ST_CHECK;
        end
      end
      // limit test: min first, then max
      ST_CHECK: begin
        if ($signed(cand) < $signed(lo42)) begin
          lim_nxt   = omin_r;
          state_nxt = ST_DIV_LIM;
        end else if ($signed(cand) > $signed(hi42)) begin
          lim_nxt   = omax_r;
          state_nxt = ST_DIV_LIM;
        end else begin
          integ_nxt = acc_r;
          if ($signed(cand) > 42'sh7FFFFF)        res_nxt = 24'h7FFFFF;
          else if ($signed(cand) < -42'sh800000)  res_nxt = 24'h800000;
          else                                    res_nxt = cand[23:0];
          state_nxt = ST_OUT;
        end
      end
      // limit over gain
      ST_DIV_LIM: begin
        cmd.op  = OP_DIV;
        cmd.opa = {16'd0, (lim_r[23] ? (24'd0 - lim_r) : lim_r), 24'd0}
                  + {41'd0, g_eff[23:1]};
        cmd.opb = g_eff;
        if (stat.done) begin
          qs         = lim_r[23] ? (64'd0 - quot) : quot;
          s_nxt      = eb64 + qs;
          issued_nxt = 1'b0;
          state_nxt  = ST_MUL_BACK;
        end
      end
      // back-computed integral
      ST_MUL_BACK: begin
        cmd.op  = OP_MUL;
        cmd.opa = abs64(s_r);
        cmd.opb = t_eff;
        if (stat.done) begin
          rb = prod[87:8] + {80'd0, prod[7]};
          mb = (rb > 81'h8000_0000_0000) ? 48'h8000_0000_0000 : rb[47:0];
          if (s_r[63]) begin
            integ_nxt = mb[47] ? 48'h7FFF_FFFF_FFFF : mb;
          end else begin
            integ_nxt = 48'd0 - mb;
          end
          res_nxt    = lim_r;
          issued_nxt = 1'b0;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_airflow_rate = res_r;

endmodule

// ----- design/pida_serial_unit.sv -----
// ----------------------------------------------------------------------------
// pida_serial_unit
// shared bit-serial unit: shift-add multiply and restoring divide, one bit a cycle
// ----------------------------------------------------------------------------
module pida_serial_unit import pida_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  su_cmd_t     cmd_i,
  output su_stat_t    stat_o,
  output logic [87:0] prod_o,
  output logic [63:0] quot_o
);

  op_t         op_r,   op_nxt;
  logic [6:0]  cnt_r,  cnt_nxt;
  logic        done_r, done_nxt;
  logic [87:0] p_r,    p_nxt;
  logic [63:0] a_r,    a_nxt;
  logic [23:0] d_r,    d_nxt;
  logic [23:0] rem_r,  rem_nxt;

  logic [64:0] sum;
  logic [24:0] trial;
  logic [24:0] diff;
  logic        ge;

  always_comb begin
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    p_nxt    = p_r;
    a_nxt    = a_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    sum   = {1'b0, p_r[87:24]} + (p_r[0] ? {1'b0, a_r} : 65'd0);
    trial = {rem_r, p_r[63]};
    diff  = trial - {1'b0, d_r};
    ge    = (trial >= {1'b0, d_r});
    if (cmd_i.start) begin
      op_nxt  = cmd_i.op;
      a_nxt   = cmd_i.opa;
      d_nxt   = cmd_i.opb;
      rem_nxt = 24'd0;
      if (cmd_i.op == OP_MUL) begin
        p_nxt   = {64'd0, cmd_i.opb};
        cnt_nxt = MUL_STEPS;
      end else begin
        p_nxt   = {24'd0, cmd_i.opa};
        cnt_nxt = DIV_STEPS;
      end
    end else if (cnt_r != 7'd0) begin
      cnt_nxt  = cnt_r - 7'd1;
      done_nxt = (cnt_r == 7'd1);
      if (op_r == OP_MUL) begin
        p_nxt = {sum, p_r[23:1]};
      end else begin
        rem_nxt = ge ? diff[23:0] : trial[23:0];
        p_nxt   = {24'd0, p_r[62:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 7'd0;
      done_r <= 1'b0;
      op_r   <= OP_MUL;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
    end
    p_r   <= p_nxt;
    a_r   <= a_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign stat_o.busy = (cnt_r != 7'd0);
  assign stat_o.done = done_r;
  assign prod_o      = p_r;
  assign quot_o      = p_r[63:0];

endmodule

// ----- design/pida_checker.sv -----
// ----------------------------------------------------------------------------
// pida_checker
// port-level checks of the controller's handshakes over time
// ----------------------------------------------------------------------------
module pida_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_airflow_rate,
  input logic        pready
);

  // a result beat waits with its value held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_airflow_rate))
    else $error("result beat dropped or changed while stalled");

  // one item at a time: no input taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  // an accepted input closes the input side next cycle
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("block not busy after input beat");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind pi_deadband_antiwindup pida_checker u_pida_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_airflow_rate (out_airflow_rate),
  .pready           (pready)
);
